@@ sv/pts_pkg.sv @@
// ============================================================================
// pts_pkg
// Shared types and constants of the priority task scheduler: command and
// task status codes, fixed field widths and the scan control bundle.
// ============================================================================
package pts_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_TASKS_DEF  = 8;
  localparam int TICK_WIDTH_DEF = 32;

  // Fixed widths of the request and result fields.
  localparam int CMD_W       = 3;
  localparam int PRIO_W      = 7;
  localparam int TIDX_W      = 3;
  localparam int DLY_W       = 32;
  localparam int TCNT_W      = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Command codes; codes six and seven are unused.
  typedef enum logic [CMD_W-1:0] {
    CMD_START    = 3'd0,
    CMD_CREATE   = 3'd1,
    CMD_DELAY    = 3'd2,
    CMD_SUSPEND  = 3'd3,
    CMD_ACTIVATE = 3'd4,
    CMD_TICK     = 3'd5
  } cmd_t;

  // Task status codes as stored in the task table.
  typedef enum logic [1:0] {
    ST_READY     = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_WAITING   = 2'd2,
    ST_SUSPENDED = 2'd3
  } status_t;

  // Control from the sequencer to the scan unit for one table entry.
  typedef struct packed {
    logic clear;  // start of a new scan: forget the best candidate
    logic valid;  // table read data is present this cycle
    logic hit;    // the entry read is the target of the command
    cmd_t cmd;    // command being executed
  } scan_ctl_t;

endpackage

@@ sv/priority_task_scheduler.sv @@
// ============================================================================
// priority_task_scheduler
// Fixed-priority preemptive task scheduler control: task table, delays,
// tick countdown and dispatch with context switch requests.
// ============================================================================
// Usage:
// Requests arrive on the s_t* stream, one command each; every request gives
// exactly one result on the m_t* stream, in order. The result carries the
// current task, whether this request switched tasks, the create status and
// handle, and the tick count.
// Start and create write one table entry, if the table has room, and go
// from decode straight to the result. Delay, suspend, activate and tick walk
// the task table through its single read port, one entry per cycle,
// reading, updating and writing back each entry, then write the running
// status of a newly chosen task before the result. An activate of a task
// that does not exist skips the walk and goes to the result like a create.
// One request is worked on at a time; the next one is taken once the
// result sits in the output register, so a stalled receiver holds back
// at most the request after the one waiting.
// Reset clears the task count, current task and tick count; table entries
// are only read once created. A result waits in the output register for as
// long as m_tready stays low.
// ============================================================================
module priority_task_scheduler import pts_pkg::*; #(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // command[2:0], priority_req[9:3], autostart[10], task_index[13:11],
  // delay_ticks[45:14], zero fill[47:46]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // current_valid[0], run_task[3:1], switch_request[4], create_ok[5],
  // created_handle[8:6], tick_count[40:9], zero fill[47:41]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int CMP_W  = (CNT_W > TIDX_W) ? CNT_W : TIDX_W;
  localparam int WORD_W = PRIO_W + 2 + TICK_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FIN,
    S_OUT
  } state_t;

  state_t                state;
  cmd_t                  cmd_q;
  logic [PRIO_W-1:0]     prio_q;
  logic                  auto_q;
  logic [TIDX_W-1:0]     idx_q;
  logic [TICK_WIDTH-1:0] dly_q;
  logic [CNT_W-1:0]      task_count;
  logic [IDX_W-1:0]      run_idx;
  logic                  run_valid;
  logic [TICK_WIDTH-1:0] ticks;
  logic [CNT_W-1:0]      scan_idx;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_idx;
  logic                  hit_en;
  logic [IDX_W-1:0]      target;
  logic                  sw_q;
  logic                  ok_q;
  logic [TIDX_W-1:0]     handle_q;

  logic                  has_room;
  logic                  add_ok;
  logic                  act_in_range;
  logic                  switch_take;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [WORD_W-1:0]     rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic [OUT_TDATA_W-1:0] out_word;

  scan_ctl_t             ctl;
  logic [PRIO_W-1:0]     ent_prio;
  status_t               ent_status;
  logic [TICK_WIDTH-1:0] ent_wait;
  status_t               upd_status;
  logic [TICK_WIDTH-1:0] upd_wait;
  logic                  best_found;
  logic [IDX_W-1:0]      best_idx;
  logic [PRIO_W-1:0]     best_prio;
  logic [TICK_WIDTH-1:0] best_wait;

  assign s_tready = (state == S_IDLE);

  // Table entry layout: priority, status, wait counter.
  assign ent_prio   = rd_data[WORD_W-1 -: PRIO_W];
  assign ent_status = status_t'(rd_data[TICK_WIDTH+1:TICK_WIDTH]);
  assign ent_wait   = rd_data[TICK_WIDTH-1:0];

  // Decode helpers.
  assign has_room     = task_count < CNT_W'(MAX_TASKS);
  assign add_ok       = (cmd_q == CMD_START || cmd_q == CMD_CREATE) && has_room;
  assign act_in_range = CMP_W'(idx_q) < CMP_W'(task_count);
  assign switch_take  = best_found && (!run_valid || best_idx != run_idx);

  // Table walk reads.
  assign rd_en   = (state == S_SCAN) && (scan_idx < task_count);
  assign rd_addr = scan_idx[IDX_W-1:0];

  // Scan unit control.
  always_comb begin
    ctl.clear = (state == S_DECODE);
    ctl.valid = rd_vld;
    ctl.hit   = rd_vld && hit_en && (rd_idx == target);
    ctl.cmd   = cmd_q;
  end

  // Table writes: new task, walk write-back, or the chosen task's status.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = {ent_prio, upd_status, upd_wait};
    unique case (state)
      S_DECODE: begin
        wr_addr = task_count[IDX_W-1:0];
        if (cmd_q == CMD_START) begin
          wr_en   = has_room;
          wr_data = {{PRIO_W{1'b0}}, ST_READY, {TICK_WIDTH{1'b0}}};
        end else if (cmd_q == CMD_CREATE) begin
          wr_en   = has_room;
          wr_data = {prio_q, (auto_q ? ST_READY : ST_SUSPENDED), {TICK_WIDTH{1'b0}}};
        end
      end
      S_SCAN: begin
        wr_en = rd_vld;
      end
      S_FIN: begin
        wr_en   = switch_take;
        wr_addr = best_idx;
        wr_data = {best_prio, ST_RUNNING, best_wait};
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Result packing.
  always_comb begin
    out_word = '0;
    out_word[0]    = run_valid;
    out_word[3:1]  = run_valid ? TIDX_W'(run_idx) : '0;
    out_word[4]    = sw_q;
    out_word[5]    = ok_q;
    out_word[8:6]  = handle_q;
    out_word[40:9] = TCNT_W'(ticks);
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      task_count <= '0;
      run_idx    <= '0;
      run_valid  <= 1'b0;
      ticks      <= '0;
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // A result taken while no new one is loaded empties the register.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q  <= cmd_t'(s_tdata[2:0]);
            prio_q <= s_tdata[9:3];
            auto_q <= s_tdata[10];
            idx_q  <= s_tdata[13:11];
            dly_q  <= TICK_WIDTH'(s_tdata[45:14]);
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          sw_q     <= 1'b0;
          ok_q     <= add_ok;
          handle_q <= add_ok ? TIDX_W'(task_count) : '0;
          scan_idx <= '0;
          hit_en   <= (cmd_q == CMD_ACTIVATE) ||
                      ((cmd_q inside {CMD_DELAY, CMD_SUSPEND}) && run_valid);
          target   <= (cmd_q == CMD_ACTIVATE) ? IDX_W'(idx_q) : run_idx;
          unique case (cmd_q) inside
            CMD_START, CMD_CREATE: begin
              if (cmd_q == CMD_START) begin
                ticks     <= '0;
                run_valid <= 1'b0;
              end
              if (add_ok) begin
                task_count <= task_count + CNT_W'(1);
              end
              state <= S_OUT;
            end
            CMD_DELAY, CMD_SUSPEND: begin
              state <= S_SCAN;
            end
            CMD_ACTIVATE: begin
              state <= act_in_range ? S_SCAN : S_OUT;
            end
            CMD_TICK: begin
              ticks <= ticks + TICK_WIDTH'(1);
              state <= S_SCAN;
            end
            default: state <= S_OUT;
          endcase
        end
        S_SCAN: begin
          rd_vld <= rd_en;
          rd_idx <= rd_addr;
          if (rd_en) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (!rd_en && !rd_vld) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (switch_take) begin
            run_idx   <= best_idx;
            run_valid <= 1'b1;
            sw_q      <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= out_word;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pts_task_ram #(
    .DEPTH  (MAX_TASKS),
    .ADDR_W (IDX_W),
    .DATA_W (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pts_scan_unit #(
    .IDX_W      (IDX_W),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .ent_idx     (rd_idx),
    .ent_prio    (ent_prio),
    .ent_status  (ent_status),
    .ent_wait    (ent_wait),
    .delay_ticks (dly_q),
    .upd_status  (upd_status),
    .upd_wait    (upd_wait),
    .best_found  (best_found),
    .best_idx    (best_idx),
    .best_prio   (best_prio),
    .best_wait   (best_wait)
  );

  // Table read data only arrives during a walk.
  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == S_SCAN)
    else $error("table read data outside of a walk");

  // A walk never reads an entry that was not created.
  a_rd_created: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> CNT_W'(rd_idx) < task_count)
    else $error("walk read beyond task count");

  // The current task always is a created task.
  a_run_created: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> CNT_W'(run_idx) < task_count)
    else $error("current task beyond task count");

  // A requested switch leaves a valid current task in the result.
  a_switch_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && switch_take) |=> (run_valid && sw_q))
    else $error("switch without a current task");

endmodule

@@ sv/pts_task_ram.sv @@
// ============================================================================
// pts_task_ram
// Task table memory: one write port and one read port, read data registered.
// ============================================================================
module pts_task_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int DATA_W = 41
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/pts_scan_unit.sv @@
// ============================================================================
// pts_scan_unit
// Per-entry update and dispatch selection. Applies the command to the entry
// read from the task table, counts down waiting tasks on a tick, and keeps
// the best ready or running candidate seen so far in the scan.
// ============================================================================
module pts_scan_unit import pts_pkg::*; #(
  parameter int IDX_W      = 3,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scan_ctl_t             ctl,
  input  logic [IDX_W-1:0]      ent_idx,
  input  logic [PRIO_W-1:0]     ent_prio,
  input  status_t               ent_status,
  input  logic [TICK_WIDTH-1:0] ent_wait,
  input  logic [TICK_WIDTH-1:0] delay_ticks,
  output status_t               upd_status,
  output logic [TICK_WIDTH-1:0] upd_wait,
  output logic                  best_found,
  output logic [IDX_W-1:0]      best_idx,
  output logic [PRIO_W-1:0]     best_prio,
  output logic [TICK_WIDTH-1:0] best_wait
);

  status_t               st_mod;
  logic [TICK_WIDTH-1:0] wait_mod;
  logic                  eligible;
  logic                  take;

  // Apply the command to the target entry, then the tick countdown.
  always_comb begin
    st_mod   = ent_status;
    wait_mod = ent_wait;
    if (ctl.hit) begin
      unique case (ctl.cmd)
        CMD_DELAY: begin
          st_mod   = ST_WAITING;
          wait_mod = delay_ticks;
        end
        CMD_SUSPEND:  st_mod = ST_SUSPENDED;
        CMD_ACTIVATE: st_mod = ST_READY;
        default:      st_mod = ent_status;
      endcase
    end
    upd_status = st_mod;
    upd_wait   = wait_mod;
    if (ctl.cmd == CMD_TICK && st_mod == ST_WAITING) begin
      upd_wait = wait_mod - TICK_WIDTH'(1);
      if (upd_wait == '0) begin
        upd_status = ST_READY;
      end
    end
    eligible = (upd_status == ST_READY) || (upd_status == ST_RUNNING);
    take     = ctl.valid && eligible && (!best_found || ent_prio > best_prio);
  end

  // Candidate flag: strict compare keeps the lowest index on equal priority.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (ctl.clear) begin
      best_found <= 1'b0;
    end else if (take) begin
      best_found <= 1'b1;
    end
  end

  // Candidate payload, kept for the final write of the running status.
  always_ff @(posedge clk) begin
    if (take) begin
      best_idx  <= ent_idx;
      best_prio <= ent_prio;
      best_wait <= upd_wait;
    end
  end

endmodule
